[design/bgm_pkg.sv]
`default_nettype none
package bgm_pkg;

  localparam int CFG_W = 6;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_FONT_HEIGHT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE_GLYPHS = 1'd1;

  localparam logic [5:0] FONT_HEIGHT_RESET = 6'd16;

  localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;
  localparam logic [6:0] CHAR_DASH = 7'h2D;
  localparam logic [6:0] CHAR_BAR = 7'h7C;
  localparam logic [6:0] CHAR_PLUS = 7'h2B;
  localparam logic [6:0] CHAR_HASH = 7'h23;

  typedef struct packed {
    logic clear;
    logic rd_en;
    logic record;
    logic publish;
  } bgm_cmd_t;

  typedef struct packed {
    logic hit;
    logic cmp_valid;
    logic height_zero;
  } bgm_status_t;

  function automatic logic [6:0] to_char(input logic [7:0] g);
    logic [6:0] c;
    if (g >= 8'd32 && g <= 8'd127) begin
      c = g[6:0];
    end else begin
      case (g)
        8'd1, 8'd196: c = CHAR_DASH;
        8'd176, 8'd177, 8'd219: c = CHAR_HASH;
        8'd179: c = CHAR_BAR;
        8'd180, 8'd191, 8'd192, 8'd193, 8'd194, 8'd195, 8'd197,
        8'd217, 8'd218, 8'd223: c = CHAR_PLUS;
        default: c = CHAR_UNKNOWN;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[design/bgm_ctrl.sv]
`default_nettype none
module bgm_ctrl #(
  parameter int GLYPH_COUNT = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire bgm_pkg::bgm_status_t           status,
  input  wire logic                           out_ready,
  output logic                                in_ready,
  output logic                                out_valid,
  output bgm_pkg::bgm_cmd_t                   cmd,
  output logic [$clog2(GLYPH_COUNT)-1:0]      rd_addr
);
  import bgm_pkg::*;

  localparam int GW = $clog2(GLYPH_COUNT);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [GW:0] issue_cnt;
  logic [GW:0] issue_cnt_next;
  logic issue_done;

  assign issue_done = (issue_cnt == (GW+1)'(GLYPH_COUNT));
  assign rd_addr = issue_cnt[GW-1:0];
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    issue_cnt_next = issue_cnt;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.clear = 1'b1;
          issue_cnt_next = '0;
          state_next = status.height_zero ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue_done) begin
          cmd.rd_en = 1'b1;
          issue_cnt_next = issue_cnt + 1'b1;
        end
        if (status.hit) begin
          cmd.record = 1'b1;
          state_next = ST_DONE;
        end else if (issue_done && !status.cmp_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      issue_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      issue_cnt <= issue_cnt_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[design/bgm_datapath.sv]
`default_nettype none
module bgm_datapath #(
  parameter int GLYPH_COUNT = 256,
  parameter int MAX_ROWS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [bgm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [bgm_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                               in_acc,
  input  wire logic                               action,
  input  wire logic [7:0]                         glyph_number,
  input  wire logic [4:0]                         row_number,
  input  wire logic [15:0]                        row_bits,
  input  wire bgm_pkg::bgm_cmd_t                  cmd,
  input  wire logic [$clog2(GLYPH_COUNT)-1:0]     rd_addr,
  output bgm_pkg::bgm_status_t                    status,
  output logic [6:0]                              char_code,
  output logic                                    found,
  output logic [7:0]                              matched_glyph,
  output logic                                    was_inverted
);
  import bgm_pkg::*;

  localparam int GW = $clog2(GLYPH_COUNT);
  localparam int RW = $clog2(MAX_ROWS);

  logic [5:0] font_height;
  logic wide_glyphs;

  logic [MAX_ROWS-1:0][15:0] glyph_mem [GLYPH_COUNT];
  logic [MAX_ROWS-1:0][15:0] rd_data;
  logic [MAX_ROWS-1:0][15:0] cell_rows;
  logic [GW-1:0] cmp_idx;
  logic cmp_valid;

  logic row_ok;
  logic glyph_ok;
  logic [15:0] mask;
  logic [MAX_ROWS-1:0] row_same;
  logic [MAX_ROWS-1:0] row_comp;
  logic all_same;
  logic all_comp;

  logic match_found;
  logic [GW-1:0] match_idx;
  logic match_inv;

  assign row_ok = (32'(row_number) < MAX_ROWS);
  assign glyph_ok = (32'(glyph_number) < GLYPH_COUNT);
  assign mask = wide_glyphs ? 16'hFFFF : 16'h00FF;

  always_ff @(posedge clk) begin
    if (rst) begin
      font_height <= FONT_HEIGHT_RESET;
      wide_glyphs <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FONT_HEIGHT: font_height <= cfg_data;
        REG_WIDE_GLYPHS: wide_glyphs <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !action && row_ok && glyph_ok) begin
      glyph_mem[glyph_number[GW-1:0]][row_number[RW-1:0]] <= row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= glyph_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && action && row_ok) begin
      cell_rows[row_number[RW-1:0]] <= row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.rd_en;
    end
    cmp_idx <= rd_addr;
  end

  always_comb begin
    for (int y = 0; y < MAX_ROWS; y++) begin
      if (32'(font_height) > y) begin
        row_same[y] = ((cell_rows[y] & mask) == (rd_data[y] & mask));
        row_comp[y] = ((~cell_rows[y] & mask) == (rd_data[y] & mask));
      end else begin
        row_same[y] = 1'b1;
        row_comp[y] = 1'b1;
      end
    end
  end

  assign all_same = &row_same;
  assign all_comp = &row_comp;

  assign status.hit = cmp_valid && (all_same || all_comp);
  assign status.cmp_valid = cmp_valid;
  assign status.height_zero = (font_height == 6'd0);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      match_found <= 1'b0;
      match_idx <= '0;
      match_inv <= 1'b0;
    end else if (cmd.record) begin
      match_found <= 1'b1;
      match_idx <= cmp_idx;
      match_inv <= !all_same;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      found <= match_found;
      matched_glyph <= 8'(match_idx);
      was_inverted <= match_inv;
      char_code <= match_found ? to_char(8'(match_idx)) : CHAR_UNKNOWN;
    end
  end

endmodule
`default_nettype wire

[design/bitmap_glyph_matcher_unit.sv]
// A glyph row or a cell row without the final flag is written to its store when accepted.
// A final cell row starts a scan of one glyph per cycle (skipped if font_height is zero);
// the result follows the hit or scan end and is held until taken; requests resume with it.
// The scan rate is set by the single read port of the font memory.
// Reset restores font_height 16 and narrow glyphs; font and cell rows keep
// their contents and are undefined until written.
`default_nettype none
module bitmap_glyph_matcher_unit #(
  parameter int GLYPH_COUNT = 256,
  parameter int MAX_ROWS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [bgm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bgm_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             action,
  input  wire logic [7:0]                       glyph_number,
  input  wire logic [4:0]                       row_number,
  input  wire logic [15:0]                      row_bits,
  input  wire logic                             cell_done,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [6:0]                            char_code,
  output logic                                  found,
  output logic [7:0]                            matched_glyph,
  output logic                                  was_inverted
);
  import bgm_pkg::*;

  localparam int GW = $clog2(GLYPH_COUNT);

  logic in_acc;
  logic start;
  bgm_cmd_t cmd;
  bgm_status_t status;
  logic [GW-1:0] rd_addr;

  assign in_acc = in_valid && in_ready;
  assign start = in_acc && action && cell_done;

  bgm_ctrl #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .status(status),
    .out_ready(out_ready),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .cmd(cmd),
    .rd_addr(rd_addr)
  );

  bgm_datapath #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .MAX_ROWS(MAX_ROWS)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_acc(in_acc),
    .action(action),
    .glyph_number(glyph_number),
    .row_number(row_number),
    .row_bits(row_bits),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .status(status),
    .char_code(char_code),
    .found(found),
    .matched_glyph(matched_glyph),
    .was_inverted(was_inverted)
  );

`ifndef NO_ASSERTIONS
  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("Final cell row did not make the block busy.");

  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("Published result is not presented.");

  a_no_match_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (matched_glyph == 8'd0 && !was_inverted
      && char_code == CHAR_UNKNOWN))
    else $error("Result without a match carries match fields.");

  a_read_only_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !in_ready)
    else $error("Font read issued while requests are accepted.");
`endif

endmodule
`default_nettype wire
